/* src/lobm_pkg.sv */
// Package of the limit order book matcher: sizes, storage entry types and sequencer states.
// Depends on nothing; the two channel interfaces and the top level import it.
package lobm_pkg;

	localparam int PRICE_LEVELS = 1024;
	localparam int ORDER_SLOTS  = 1024;
	localparam int PRICE_W      = 10;
	localparam int SLOT_W       = 10;
	localparam int UNITS_W      = 24;
	localparam int VOL_W        = 40;
	localparam int ID_W         = 32;
	localparam int LEVEL_CNT_W  = 11;
	localparam int SLOT_CNT_W   = 11;
	localparam int TOUCH_W      = 10;
	localparam int REMOVED_W    = 11;

	// Marker for "no level on this side"; one past the highest price.
	localparam logic [LEVEL_CNT_W-1:0] EMPTY_LEVEL = LEVEL_CNT_W'(PRICE_LEVELS);
	localparam logic [SLOT_CNT_W-1:0]  ALL_SLOTS   = SLOT_CNT_W'(ORDER_SLOTS);

	// One price level: FIFO ends and total resting volume.
	typedef struct packed {
		logic               active;
		logic               side;
		logic [VOL_W-1:0]   volume;
		logic [SLOT_W-1:0]  head;
		logic [SLOT_W-1:0]  tail;
	} level_t;

	// One resting order.
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [UNITS_W-1:0] units;
	} slot_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MATCH,
		ST_LVL_LOAD,
		ST_POP_ISSUE,
		ST_POP_DATA,
		ST_SCAN_ISSUE,
		ST_SCAN_CHK,
		ST_REST,
		ST_REST_WR,
		ST_REST_LINK,
		ST_DONE
	} state_t;

endpackage

/* src/lobm_order_if.sv */
// Channel carrying one incoming order per beat.
// Depends on lobm_pkg for the field widths.
interface lobm_order_if;
	import lobm_pkg::*;

	logic               valid;
	logic               ready;
	logic [ID_W-1:0]    order_id;
	logic               is_buy;
	logic [PRICE_W-1:0] limit_price;
	logic [UNITS_W-1:0] order_units;

	modport source (output valid, order_id, is_buy, limit_price, order_units, input ready);
	modport sink   (input valid, order_id, is_buy, limit_price, order_units, output ready);
endinterface

/* src/lobm_result_if.sv */
// Channel carrying one fill summary per beat.
// Depends on lobm_pkg for the field widths.
interface lobm_result_if;
	import lobm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [UNITS_W-1:0]   units_filled;
	logic [UNITS_W-1:0]   units_unfilled;
	logic [UNITS_W-1:0]   units_in_book;
	logic [PRICE_W-1:0]   first_fill_price;
	logic [PRICE_W-1:0]   last_fill_price;
	logic [TOUCH_W-1:0]   levels_touched;
	logic [REMOVED_W-1:0] orders_removed;
	logic                 book_full;

	modport source (output valid, units_filled, units_unfilled, units_in_book, first_fill_price,
		last_fill_price, levels_touched, orders_removed, book_full, input ready);
	modport sink   (input valid, units_filled, units_unfilled, units_in_book, first_fill_price,
		last_fill_price, levels_touched, orders_removed, book_full, output ready);
endinterface

/* src/limit_order_book_matcher.sv */
// Price-time priority limit order book matcher: top level with sequencer and storage.
// Depends on lobm_pkg, lobm_order_if, lobm_result_if and lobm_ram.
//
// After reset the block clears the level store and chains the free list, and accepts no
// order meanwhile. Each order then enters in ST_IDLE; each price level checked against the
// limit passes ST_MATCH and ST_LVL_LOAD, each resting order taken from a level ST_POP_ISSUE
// and ST_POP_DATA, and each price step of the search for a new best price of a side after a
// level empties ST_SCAN_ISSUE and ST_SCAN_CHK. A remainder rests through ST_REST, ST_REST_WR
// and, if its level is in use, ST_REST_LINK; ST_DONE hands over the summary.
// Every step is one access through the single read port of the level, slot or link memory,
// which sets the pace. The summary waits in an output register, so a new order can be taken
// while it is still held.
module limit_order_book_matcher (
	input logic clk,
	input logic arst_n,
	lobm_order_if.sink    ord,
	lobm_result_if.source res
);
	import lobm_pkg::*;

	state_t state_q, state_d;

	// Order being worked on and its running summary.
	logic [ID_W-1:0]        oid_q;
	logic                   buy_q;
	logic [PRICE_W-1:0]     limit_q;
	logic [UNITS_W-1:0]     units_q;
	logic [UNITS_W-1:0]     unfilled_q;
	logic [UNITS_W-1:0]     filled_q;
	logic [UNITS_W-1:0]     inbook_q;
	logic [PRICE_W-1:0]     first_q;
	logic [PRICE_W-1:0]     last_q;
	logic [TOUCH_W-1:0]     touched_q;
	logic [REMOVED_W-1:0]   removed_q;
	logic                   full_q;

	// Book bookkeeping.
	logic [PRICE_W-1:0]     p_q;
	level_t                 lvl_q;
	logic [LEVEL_CNT_W-1:0] scan_q;
	logic [SLOT_W-1:0]      free_head_q;
	logic [SLOT_CNT_W-1:0]  free_count_q;
	logic [LEVEL_CNT_W-1:0] best_bid_q;
	logic [LEVEL_CNT_W-1:0] best_ask_q;
	logic [SLOT_CNT_W-1:0]  clr_q;
	logic [SLOT_W-1:0]      rest_slot_q;

	// Result register.
	logic                   res_valid_q;
	logic [UNITS_W-1:0]     r_filled_q;
	logic [UNITS_W-1:0]     r_unfilled_q;
	logic [UNITS_W-1:0]     r_inbook_q;
	logic [PRICE_W-1:0]     r_first_q;
	logic [PRICE_W-1:0]     r_last_q;
	logic [TOUCH_W-1:0]     r_touched_q;
	logic [REMOVED_W-1:0]   r_removed_q;
	logic                   r_full_q;

	// Memory ports.
	logic                   lvl_we;
	logic [PRICE_W-1:0]     lvl_waddr, lvl_raddr;
	level_t                 lvl_wdata, lvl_rd;
	logic                   slot_we;
	logic [SLOT_W-1:0]      slot_waddr, slot_raddr;
	slot_t                  slot_wdata, slot_rd;
	logic                   nxt_we;
	logic [SLOT_W-1:0]      nxt_waddr, nxt_wdata, nxt_rd;
	logic [SLOT_W-1:0]      nxt_raddr_w;

	lobm_ram #(.WIDTH($bits(level_t)), .DEPTH(PRICE_LEVELS)) u_level_ram (
		.clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
		.raddr(lvl_raddr), .rdata(lvl_rd)
	);

	lobm_ram #(.WIDTH($bits(slot_t)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rd)
	);

	lobm_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_next_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(nxt_raddr_w), .rdata(nxt_rd)
	);

	assign nxt_raddr_w = slot_raddr;

	// Handshakes.
	logic ord_acc, res_load;
	assign ord.ready = (state_q == ST_IDLE);
	assign ord_acc   = ord.valid && ord.ready;
	assign res_load  = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// Best opposite price and whether the limit allows it.
	logic [LEVEL_CNT_W-1:0] opp_best;
	logic                   px_ok, match_go;
	assign opp_best = buy_q ? best_ask_q : best_bid_q;
	always_comb begin
		px_ok = 1'b1;
		if (limit_q != '0) begin
			px_ok = buy_q ? (opp_best[PRICE_W-1:0] <= limit_q)
				: (opp_best[PRICE_W-1:0] >= limit_q);
		end
	end
	assign match_go = (unfilled_q != '0) && (opp_best != EMPTY_LEVEL) && px_ok;

	// Taking the head order of the current level.
	logic               take_all, lvl_done;
	logic [VOL_W-1:0]   vol_after;
	logic [UNITS_W-1:0] unf_after;
	assign take_all  = unfilled_q >= slot_rd.units;
	assign vol_after = lvl_q.volume - VOL_W'(slot_rd.units);
	assign unf_after = unfilled_q - slot_rd.units;
	assign lvl_done  = take_all && (vol_after == '0);

	// Next candidate level of the best-price search.
	logic [LEVEL_CNT_W-1:0] scan_start, scan_step;
	logic                   scan_hit;
	assign scan_start = buy_q ? (LEVEL_CNT_W'(p_q) + LEVEL_CNT_W'(1))
		: ((p_q == '0) ? EMPTY_LEVEL : LEVEL_CNT_W'(p_q) - LEVEL_CNT_W'(1));
	assign scan_step  = buy_q ? (scan_q + LEVEL_CNT_W'(1))
		: ((scan_q == '0) ? EMPTY_LEVEL : scan_q - LEVEL_CNT_W'(1));
	assign scan_hit   = lvl_rd.active && (lvl_rd.side != buy_q);

	// Whether the remainder goes to rest.
	logic rest_wanted;
	assign rest_wanted = (unfilled_q != '0) && (limit_q != '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ALL_SLOTS - SLOT_CNT_W'(1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (ord_acc) state_d = ST_MATCH;
			end
			ST_MATCH: begin
				state_d = match_go ? ST_LVL_LOAD : ST_REST;
			end
			ST_LVL_LOAD:  state_d = ST_POP_ISSUE;
			ST_POP_ISSUE: state_d = ST_POP_DATA;
			ST_POP_DATA: begin
				if (!take_all)          state_d = ST_MATCH;
				else if (lvl_done)      state_d = ST_SCAN_ISSUE;
				else if (unf_after == '0) state_d = ST_MATCH;
				else                    state_d = ST_POP_ISSUE;
			end
			ST_SCAN_ISSUE: begin
				state_d = (scan_q == EMPTY_LEVEL) ? ST_MATCH : ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				state_d = scan_hit ? ST_MATCH : ST_SCAN_ISSUE;
			end
			ST_REST: begin
				if (rest_wanted && free_count_q != '0) state_d = ST_REST_WR;
				else                                  state_d = ST_DONE;
			end
			ST_REST_WR: begin
				state_d = lvl_rd.active ? ST_REST_LINK : ST_DONE;
			end
			ST_REST_LINK: state_d = ST_DONE;
			ST_DONE: begin
				if (res_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		lvl_we     = 1'b0;
		lvl_waddr  = p_q;
		lvl_wdata  = lvl_q;
		lvl_raddr  = opp_best[PRICE_W-1:0];
		slot_we    = 1'b0;
		slot_waddr = lvl_q.head;
		slot_wdata = '{id: slot_rd.id, units: slot_rd.units - unfilled_q};
		slot_raddr = lvl_q.head;
		nxt_we     = 1'b0;
		nxt_waddr  = lvl_q.head;
		nxt_wdata  = free_head_q;
		unique case (state_q)
			ST_CLEAR: begin
				lvl_we    = 1'b1;
				lvl_waddr = clr_q[PRICE_W-1:0];
				lvl_wdata = '0;
				nxt_we    = 1'b1;
				nxt_waddr = clr_q[SLOT_W-1:0];
				nxt_wdata = clr_q[SLOT_W-1:0] + SLOT_W'(1);
			end
			ST_POP_DATA: begin
				lvl_we = 1'b1;
				if (take_all) begin
					nxt_we = 1'b1;
					if (lvl_done) begin
						lvl_wdata = '0;
					end else begin
						lvl_wdata        = lvl_q;
						lvl_wdata.volume = vol_after;
						lvl_wdata.head   = nxt_rd;
					end
				end else begin
					slot_we          = 1'b1;
					lvl_wdata        = lvl_q;
					lvl_wdata.volume = lvl_q.volume - VOL_W'(unfilled_q);
				end
			end
			ST_SCAN_ISSUE: begin
				lvl_raddr = scan_q[PRICE_W-1:0];
			end
			ST_REST: begin
				lvl_raddr  = limit_q;
				slot_raddr = free_head_q;
			end
			ST_REST_WR: begin
				lvl_we     = 1'b1;
				lvl_waddr  = limit_q;
				if (lvl_rd.active) begin
					lvl_wdata        = lvl_rd;
					lvl_wdata.volume = lvl_rd.volume + VOL_W'(unfilled_q);
					lvl_wdata.tail   = free_head_q;
				end else begin
					lvl_wdata = '{active: 1'b1, side: buy_q, volume: VOL_W'(unfilled_q),
						head: free_head_q, tail: free_head_q};
				end
				slot_we    = 1'b1;
				slot_waddr = free_head_q;
				slot_wdata = '{id: oid_q, units: unfilled_q};
				nxt_we     = 1'b1;
				nxt_waddr  = free_head_q;
				nxt_wdata  = '0;
			end
			ST_REST_LINK: begin
				nxt_we    = 1'b1;
				nxt_waddr = lvl_q.tail;
				nxt_wdata = rest_slot_q;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			free_head_q  <= '0;
			free_count_q <= ALL_SLOTS;
			best_bid_q   <= EMPTY_LEVEL;
			best_ask_q   <= EMPTY_LEVEL;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SLOT_CNT_W'(1);
			end
			// Slot returned to the free list.
			if (state_q == ST_POP_DATA && take_all) begin
				free_head_q  <= lvl_q.head;
				free_count_q <= free_count_q + SLOT_CNT_W'(1);
			end
			// Slot taken for a resting remainder; the best price of its side may improve.
			if (state_q == ST_REST_WR) begin
				free_head_q  <= nxt_rd;
				free_count_q <= free_count_q - SLOT_CNT_W'(1);
				if (lvl_rd.active ? lvl_rd.side : buy_q) begin
					if (best_bid_q == EMPTY_LEVEL || LEVEL_CNT_W'(limit_q) > best_bid_q)
						best_bid_q <= LEVEL_CNT_W'(limit_q);
				end else begin
					if (best_ask_q == EMPTY_LEVEL || LEVEL_CNT_W'(limit_q) < best_ask_q)
						best_ask_q <= LEVEL_CNT_W'(limit_q);
				end
			end
			// The search for a new best opposite price ends.
			if ((state_q == ST_SCAN_ISSUE && scan_q == EMPTY_LEVEL)
				|| (state_q == ST_SCAN_CHK && scan_hit)) begin
				if (buy_q) best_ask_q <= scan_q;
				else       best_bid_q <= scan_q;
			end
			if (res_load)            res_valid_q <= 1'b1;
			else if (res.ready)      res_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ord_acc) begin
					oid_q      <= ord.order_id;
					buy_q      <= ord.is_buy;
					limit_q    <= ord.limit_price;
					units_q    <= ord.order_units;
					unfilled_q <= ord.order_units;
					filled_q   <= '0;
					inbook_q   <= '0;
					first_q    <= '0;
					last_q     <= '0;
					touched_q  <= '0;
					removed_q  <= '0;
					full_q     <= 1'b0;
				end
			end
			ST_MATCH: begin
				if (match_go) begin
					p_q       <= opp_best[PRICE_W-1:0];
					touched_q <= touched_q + TOUCH_W'(1);
					last_q    <= opp_best[PRICE_W-1:0];
					if (touched_q == '0) first_q <= opp_best[PRICE_W-1:0];
				end
			end
			ST_LVL_LOAD: begin
				lvl_q <= lvl_rd;
			end
			ST_POP_DATA: begin
				if (take_all) begin
					filled_q     <= filled_q + slot_rd.units;
					unfilled_q   <= unf_after;
					removed_q    <= removed_q + REMOVED_W'(1);
					lvl_q.volume <= vol_after;
					lvl_q.head   <= nxt_rd;
					scan_q       <= scan_start;
				end else begin
					filled_q   <= filled_q + unfilled_q;
					unfilled_q <= '0;
				end
			end
			ST_SCAN_CHK: begin
				if (!scan_hit) scan_q <= scan_step;
			end
			ST_REST: begin
				if (rest_wanted && free_count_q == '0) full_q <= 1'b1;
			end
			ST_REST_WR: begin
				inbook_q    <= unfilled_q;
				rest_slot_q <= free_head_q;
				lvl_q       <= lvl_rd;
			end
			default: begin
			end
		endcase
		if (res_load) begin
			r_filled_q   <= filled_q;
			r_unfilled_q <= unfilled_q;
			r_inbook_q   <= inbook_q;
			r_first_q    <= first_q;
			r_last_q     <= last_q;
			r_touched_q  <= touched_q;
			r_removed_q  <= removed_q;
			r_full_q     <= full_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.units_filled     = r_filled_q;
	assign res.units_unfilled   = r_unfilled_q;
	assign res.units_in_book    = r_inbook_q;
	assign res.first_fill_price = r_first_q;
	assign res.last_fill_price  = r_last_q;
	assign res.levels_touched   = r_touched_q;
	assign res.orders_removed   = r_removed_q;
	assign res.book_full        = r_full_q;

	// Checks on the bookkeeping.
	logic [UNITS_W-1:0] split_sum;
	assign split_sum = filled_q + unfilled_q;

	a_free_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= ALL_SLOTS)
		else $error("free slot count beyond the store size");

	a_units_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> split_sum == units_q)
		else $error("filled and unfilled units do not add up to the order");

	a_full_not_rested: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && full_q |-> inbook_q == '0)
		else $error("remainder rested although the store was full");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ord_acc |=> !ord.ready)
		else $error("order accepted while another is in work");
endmodule

/* src/lobm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lobm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
